@@ sv/spta_pkg.sv @@
// ============================================================================
// spta_pkg
// Shared types and constants for the sparse polynomial term adder.
// ============================================================================
package spta_pkg;

    localparam int MAX_TERMS = 8;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEFF_W   = 32;
    localparam int EXP_W     = 8;

    // item opcodes; code 3 is ignored
    typedef enum logic [1:0] {
        FUNC_LOAD1   = 2'd0,
        FUNC_LOAD2   = 2'd1,
        FUNC_COMPUTE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT_A,
        S_PAIR,
        S_SOLO,
        S_LEFT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXP_W-1:0]          x;
        logic [EXP_W-1:0]          y;
        logic [EXP_W-1:0]          z;
    } t_term;

    // table write request
    typedef struct packed {
        logic  en;
        logic  second;
        t_term term;
    } t_wr_req;

    // sequencer -> output stage
    typedef struct packed {
        logic push;
        logic flush;
    } t_out_ctl;

endpackage

@@ sv/spta_if.sv @@
// ============================================================================
// spta_if
// Valid/ready channels for input items and result terms.
// ============================================================================
interface spta_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           func;
    logic signed [spta_pkg::COEFF_W-1:0]  coeff;
    logic [spta_pkg::EXP_W-1:0]           exp_x;
    logic [spta_pkg::EXP_W-1:0]           exp_y;
    logic [spta_pkg::EXP_W-1:0]           exp_z;

    modport source (output valid, func, coeff, exp_x, exp_y, exp_z, input ready);
    modport sink   (input valid, func, coeff, exp_x, exp_y, exp_z, output ready);
endinterface

interface spta_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spta_pkg::COEFF_W-1:0]  sum_coeff;
    logic [spta_pkg::EXP_W-1:0]           out_x;
    logic [spta_pkg::EXP_W-1:0]           out_y;
    logic [spta_pkg::EXP_W-1:0]           out_z;
    logic                                 last_term;

    modport source (output valid, sum_coeff, out_x, out_y, out_z, last_term, input ready);
    modport sink   (input valid, sum_coeff, out_x, out_y, out_z, last_term, output ready);
endinterface

@@ sv/spta_term_store.sv @@
// ============================================================================
// spta_term_store
// Two small term tables with fill counts; one write port, one read per table.
// ============================================================================
module spta_term_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spta_pkg::t_wr_req        i_wr,
    input  logic                     i_clr,
    input  logic [spta_pkg::IDX_W-1:0] i_rd_a,
    input  logic [spta_pkg::IDX_W-1:0] i_rd_b,
    output logic [spta_pkg::CNT_W-1:0] o_cnt1,
    output logic [spta_pkg::CNT_W-1:0] o_cnt2,
    output spta_pkg::t_term          o_term_a,
    output spta_pkg::t_term          o_term_b
);
    import spta_pkg::*;

    t_term            r_tab1 [MAX_TERMS];
    t_term            r_tab2 [MAX_TERMS];
    logic [CNT_W-1:0] r_cnt1;
    logic [CNT_W-1:0] r_cnt2;
    logic             wr1;
    logic             wr2;

    // loads into a full table are dropped
    assign wr1 = i_wr.en && !i_wr.second && (r_cnt1 < CNT_W'(MAX_TERMS));
    assign wr2 = i_wr.en &&  i_wr.second && (r_cnt2 < CNT_W'(MAX_TERMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1 <= '0;
            r_cnt2 <= '0;
        end else if (i_clr) begin
            r_cnt1 <= '0;
            r_cnt2 <= '0;
        end else begin
            if (wr1) r_cnt1 <= r_cnt1 + CNT_W'(1);
            if (wr2) r_cnt2 <= r_cnt2 + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr1) r_tab1[r_cnt1[IDX_W-1:0]] <= i_wr.term;
        if (wr2) r_tab2[r_cnt2[IDX_W-1:0]] <= i_wr.term;
    end

    assign o_cnt1   = r_cnt1;
    assign o_cnt2   = r_cnt2;
    assign o_term_a = r_tab1[i_rd_a];
    assign o_term_b = r_tab2[i_rd_b];

endmodule

@@ sv/spta_out_stage.sv @@
// ============================================================================
// spta_out_stage
// One-term hold plus output register; marks the final term on flush.
// ============================================================================
module spta_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spta_pkg::t_out_ctl i_ctl,
    input  spta_pkg::t_term    i_term,
    output logic               o_adv_ok,
    spta_out_if.source         o_out
);
    import spta_pkg::*;

    logic  r_hold_v;
    t_term r_hold;
    logic  r_out_v;
    t_term r_out;
    logic  r_last;
    logic  out_free;
    logic  load_out;

    // a held term can only move on when the output register frees up
    assign out_free = !r_out_v || o_out.ready;
    assign o_adv_ok = !r_hold_v || out_free;
    assign load_out = r_hold_v && out_free && (i_ctl.push || i_ctl.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_ctl.push && o_adv_ok) r_hold_v <= 1'b1;
            else if (i_ctl.flush && o_adv_ok) r_hold_v <= 1'b0;
            if (load_out) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && o_adv_ok) r_hold <= i_term;
        if (load_out) begin
            r_out  <= r_hold;
            r_last <= i_ctl.flush;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.sum_coeff = r_out.coeff;
    assign o_out.out_x     = r_out.x;
    assign o_out.out_y     = r_out.y;
    assign o_out.out_z     = r_out.z;
    assign o_out.last_term = r_last;

    property p_flush_clears_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_ctl.flush && o_adv_ok) |=> !r_hold_v;
    endproperty
    a_flush_clears_hold: assert property (p_flush_clears_hold)
        else $error("hold still valid after flush");

    property p_no_push_flush;
        @(posedge i_clk) disable iff (!i_rst_n) !(i_ctl.push && i_ctl.flush);
    endproperty
    a_no_push_flush: assert property (p_no_push_flush)
        else $error("push and flush in same cycle");

    property p_stall_holds_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_v && !o_out.ready) |=> (r_out_v && $stable(r_out) && $stable(r_last));
    endproperty
    a_stall_holds_out: assert property (p_stall_holds_out)
        else $error("output register changed while stalled");

endmodule

@@ sv/sparse_poly_term_adder.sv @@
// ============================================================================
// sparse_poly_term_adder
// Adds two sparse three-variable polynomials held in two small term tables.
// ============================================================================
// Load items (func 0 / 1) append a term to table one / table two; a load
// into a full table is dropped, func 3 is dropped. A compute item (func 2)
// runs a sequencer over one shared exponent comparator and 32-bit adder:
// for each term of table one, newest first, it scans table two newest first
// and emits the wrapped coefficient sum for every exponent match (marking
// that table-two term used); an unmatched table-one term is emitted as is,
// then unused table-two terms follow, newest first. The input is not ready
// while a compute runs. The comparator takes one step per cycle, but a step
// that emits a term waits while output back-pressure blocks the one-term
// hold. Results pass through that hold so that the final term carries
// last_term; the tables are emptied when compute ends.
// ============================================================================
module sparse_poly_term_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spta_in_if.sink     i_in,
    spta_out_if.source  o_out
);
    import spta_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_ia, n_ia;     // table-one terms still to visit
    logic [CNT_W-1:0] r_jb, n_jb;     // table-two terms still to visit
    logic             r_hit, n_hit;   // current table-one term matched
    logic [MAX_TERMS-1:0] r_used, n_used;

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [CNT_W-1:0] cnt1;
    logic [CNT_W-1:0] cnt2;
    t_term            term_a;
    t_term            term_b;
    logic             exp_match;
    t_wr_req          s_wr;
    logic             s_clr;
    t_out_ctl         s_ctl;
    t_term            s_gen;
    logic             adv_ok;

    assign idx_a = IDX_W'(r_ia - CNT_W'(1));
    assign idx_b = IDX_W'(r_jb - CNT_W'(1));

    // the shared compare unit
    assign exp_match = (term_a.x == term_b.x) && (term_a.y == term_b.y) &&
                       (term_a.z == term_b.z);

    assign i_in.ready = (r_state == S_IDLE);

    spta_term_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (s_wr),
        .i_clr    (s_clr),
        .i_rd_a   (idx_a),
        .i_rd_b   (idx_b),
        .o_cnt1   (cnt1),
        .o_cnt2   (cnt2),
        .o_term_a (term_a),
        .o_term_b (term_b)
    );

    spta_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_term   (s_gen),
        .o_adv_ok (adv_ok),
        .o_out    (o_out)
    );

    // next state and sequencer counters
    always_comb begin
        n_state = r_state;
        n_ia    = r_ia;
        n_jb    = r_jb;
        n_hit   = r_hit;
        n_used  = r_used;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.func == FUNC_COMPUTE) begin
                    n_ia    = cnt1;
                    n_state = S_NEXT_A;
                end
            end
            S_NEXT_A: begin
                n_jb    = cnt2;
                n_hit   = 1'b0;
                n_state = (r_ia == '0) ? S_LEFT : S_PAIR;
            end
            S_PAIR: begin
                if (r_jb == '0) begin
                    if (r_hit) begin
                        n_ia    = r_ia - CNT_W'(1);
                        n_state = S_NEXT_A;
                    end else begin
                        n_state = S_SOLO;
                    end
                end else if (!exp_match) begin
                    n_jb = r_jb - CNT_W'(1);
                end else if (adv_ok) begin
                    n_jb          = r_jb - CNT_W'(1);
                    n_hit         = 1'b1;
                    n_used[idx_b] = 1'b1;
                end
            end
            S_SOLO: begin
                if (adv_ok) begin
                    n_ia    = r_ia - CNT_W'(1);
                    n_state = S_NEXT_A;
                end
            end
            S_LEFT: begin
                if (r_jb == '0) begin
                    n_state = S_FLUSH;
                end else if (r_used[idx_b] || adv_ok) begin
                    n_jb = r_jb - CNT_W'(1);
                end
            end
            S_FLUSH: begin
                if (adv_ok) begin
                    n_used  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: table writes, result generation, end-of-compute clear
    always_comb begin
        s_wr.en     = 1'b0;
        s_wr.second = (i_in.func == FUNC_LOAD2);
        s_wr.term   = '{coeff: i_in.coeff, x: i_in.exp_x, y: i_in.exp_y, z: i_in.exp_z};
        s_clr       = 1'b0;
        s_ctl       = '0;
        s_gen       = term_a;
        unique case (r_state)
            S_IDLE: begin
                s_wr.en = i_in.valid &&
                          (i_in.func == FUNC_LOAD1 || i_in.func == FUNC_LOAD2);
            end
            S_PAIR: begin
                s_ctl.push  = (r_jb != '0) && exp_match;
                s_gen.coeff = term_a.coeff + term_b.coeff;
            end
            S_SOLO: begin
                s_ctl.push = 1'b1;
            end
            S_LEFT: begin
                s_ctl.push = (r_jb != '0) && !r_used[idx_b];
                s_gen      = term_b;
            end
            S_FLUSH: begin
                s_ctl.flush = 1'b1;
                s_clr       = adv_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ia    <= '0;
            r_jb    <= '0;
            r_hit   <= 1'b0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_ia    <= n_ia;
            r_jb    <= n_jb;
            r_hit   <= n_hit;
            r_used  <= n_used;
        end
    end

    property p_end_empties;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_FLUSH && adv_ok) |=>
                (cnt1 == '0 && cnt2 == '0 && r_used == '0);
    endproperty
    a_end_empties: assert property (p_end_empties)
        else $error("tables not empty after compute");

    property p_idle_no_used;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_IDLE) |-> (r_used == '0);
    endproperty
    a_idle_no_used: assert property (p_idle_no_used)
        else $error("used marks left over in idle");

    property p_counts_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
            (cnt1 <= CNT_W'(MAX_TERMS)) && (cnt2 <= CNT_W'(MAX_TERMS)) &&
            (r_jb <= cnt2) && (r_ia <= cnt1);
    endproperty
    a_counts_bounded: assert property (p_counts_bounded)
        else $error("term count out of range");

endmodule

@@ dv/spta_term_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spta_term_checker
// Watches the item and result channels, predicts result terms and compares.
// ============================================================================
// Keeps its own copy of both term tables. Every accepted compute item queues
// the expected result terms; every accepted result is checked against the
// oldest one, field by field.
// ============================================================================
module spta_term_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spta_in_if    in_mon,
    spta_out_if   out_mon,
    output int    o_errors,
    output int    o_pending
);
    import spta_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int MAX_SUMS    = MAX_TERMS * MAX_TERMS;

    typedef struct packed {
        t_term term;
        logic  last;
    } t_sum_term;

    t_term                tab1 [MAX_TERMS];
    t_term                tab2 [MAX_TERMS];
    logic [MAX_TERMS-1:0] tab2_used;
    int                   n1;
    int                   n2;
    t_sum_term            sums_due [$];

    // walk table one newest first, then the unmatched table-two terms
    task automatic add_polys();
        t_sum_term batch [MAX_SUMS];
        t_term     r;
        int        nb;
        int        a;
        int        b;
        logic      hit;
        nb = 0;
        for (a = n1 - 1; a >= 0; a--) begin
            hit = 1'b0;
            for (b = n2 - 1; b >= 0; b--) begin
                if ({tab1[a].x, tab1[a].y, tab1[a].z} ==
                    {tab2[b].x, tab2[b].y, tab2[b].z}) begin
                    r       = tab1[a];
                    r.coeff = tab1[a].coeff + tab2[b].coeff;
                    batch[nb] = '{term: r, last: 1'b0};
                    nb++;
                    tab2_used[b] = 1'b1;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                batch[nb] = '{term: tab1[a], last: 1'b0};
                nb++;
            end
        end
        for (b = n2 - 1; b >= 0; b--) begin
            if (!tab2_used[b]) begin
                batch[nb] = '{term: tab2[b], last: 1'b0};
                nb++;
            end
        end
        if (nb > 0)
            batch[nb-1].last = 1'b1;
        for (a = 0; a < nb; a++)
            sums_due.push_back(batch[a]);
        n1        = 0;
        n2        = 0;
        tab2_used = '0;
    endtask

    always @(posedge i_clk) begin : mon
        t_sum_term want;
        t_term     fresh;
        if (!i_rst_n) begin
            n1        = 0;
            n2        = 0;
            tab2_used = '0;
            sums_due.delete();
        end else begin
            // results first: a compute accepted now cannot have output yet
            if (out_mon.valid && out_mon.ready) begin
                if (sums_due.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: unexpected term coeff %0d x %0d y %0d z %0d last %0b",
                                 $time, out_mon.sum_coeff, out_mon.out_x, out_mon.out_y,
                                 out_mon.out_z, out_mon.last_term);
                end else begin
                    want = sums_due.pop_front();
                    if (want.term.coeff !== out_mon.sum_coeff || want.term.x !== out_mon.out_x ||
                        want.term.y !== out_mon.out_y || want.term.z !== out_mon.out_z ||
                        want.last !== out_mon.last_term) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= MAX_REPORTS)
                            $display({"%0t: term mismatch exp %0d (%0d,%0d,%0d) last %0b,",
                                      " got %0d (%0d,%0d,%0d) last %0b"},
                                     $time, want.term.coeff, want.term.x, want.term.y,
                                     want.term.z, want.last, out_mon.sum_coeff, out_mon.out_x,
                                     out_mon.out_y, out_mon.out_z, out_mon.last_term);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                fresh = '{coeff: in_mon.coeff, x: in_mon.exp_x, y: in_mon.exp_y,
                          z: in_mon.exp_z};
                case (in_mon.func)
                    FUNC_LOAD1: begin
                        if (n1 < MAX_TERMS) begin
                            tab1[n1] = fresh;
                            n1++;
                        end
                    end
                    FUNC_LOAD2: begin
                        if (n2 < MAX_TERMS) begin
                            tab2[n2]      = fresh;
                            tab2_used[n2] = 1'b0;
                            n2++;
                        end
                    end
                    FUNC_COMPUTE: add_polys();
                    default: ;
                endcase
            end
        end
        o_pending = sums_due.size();
    end

endmodule

@@ dv/tb_sparse_poly_term_adder.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_sparse_poly_term_adder
// Testbench for the sparse polynomial term adder.
// ============================================================================
// Drives load and compute items into the block and lets spta_term_checker
// predict and compare every result term. A short directed part covers the
// coefficient and exponent extremes, wrapping sums, a table-one term that
// matches several table-two terms, one-sided computes, an empty compute, the
// unused selector code and a load into a full table. Random polynomial pairs
// follow, with exponents drawn from small pools so that matches are common,
// and now and then full tables with one shared exponent (most results per
// compute). Sender bursts and receiver stall modes vary throughout; once the
// receiver holds off for a long stretch while items keep coming.
// ============================================================================
module tb_sparse_poly_term_adder;
    import spta_pkg::*;

    localparam int          RESET_CYCLES = 7;
    localparam int          ITEM_TARGET  = 220;
    localparam int          HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int          DRAIN_CYCLES = 150;  // idle time after the checker queue empties
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [1:0]  FUNC_IGNORED = 2'd3; // selector code the block drops

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_RANDOM,   // coin flip per cycle
        RX_SPARSE,   // ready about one cycle in four
        RX_PATTERN   // rotating 8-bit ready pattern
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spta_in_if  in_ch ();
    spta_out_if out_ch ();

    int   errors;
    int   pending;
    int   cycle_cnt  = 0;
    int   burst_left = 0;
    int   sent_items = 0;  // every input transfer, directed part included
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    sparse_poly_term_adder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spta_term_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_sparse_poly_term_adder: errors");
            $finish;
        end
    end

    // Exponents lean toward the ends of the range now and then.
    function automatic logic [7:0] rand_exp();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Entered at a falling edge; returns at the falling edge after the
    // transfer with valid still high, so back-to-back items never drop it.
    // Bursts of random length, each followed by a random gap.
    task automatic drive_item(input logic [1:0] f, input logic [31:0] c,
                              input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid = 1'b1;
        in_ch.func  = f;
        in_ch.coeff = c;
        in_ch.exp_x = x;
        in_ch.exp_y = y;
        in_ch.exp_z = z;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        sent_items++;
    endtask

    // One polynomial pair: n1 / n2 loads interleaved at random, exponents
    // from a pool of pool_n triples, a little selector-3 noise, then compute.
    // Counts above MAX_TERMS exercise the dropped load into a full table.
    task automatic run_poly_pair(input int n1, input int n2, input int pool_n);
        logic [7:0] px [4];
        logic [7:0] py [4];
        logic [7:0] pz [4];
        int         k;
        int         left1;
        int         left2;
        for (k = 0; k < pool_n; k++) begin
            px[k] = rand_exp();
            py[k] = rand_exp();
            pz[k] = rand_exp();
        end
        left1 = n1;
        left2 = n2;
        while (left1 + left2 > 0) begin
            if ($urandom_range(0, 19) == 0)
                drive_item(FUNC_IGNORED, $urandom, rand_exp(), rand_exp(), rand_exp());
            k = $urandom_range(0, pool_n - 1);
            if ($urandom_range(1, left1 + left2) <= left1) begin
                drive_item(FUNC_LOAD1, rand_coeff(), px[k], py[k], pz[k]);
                left1--;
            end else begin
                drive_item(FUNC_LOAD2, rand_coeff(), px[k], py[k], pz[k]);
                left2--;
            end
        end
        drive_item(FUNC_COMPUTE, $urandom, rand_exp(), rand_exp(), rand_exp());
    endtask

    function automatic int rand_count();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3);
        return $urandom_range(0, MAX_TERMS);
    endfunction

    // Receiver: stall mode changes when a randomly drawn span runs out. One long hold-off
    // on request, counted here, while the sender keeps offering items.
    initial begin : rx_side
        t_rx_mode   mode;
        int         mode_left;
        logic [7:0] stall_pat;
        out_ch.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        stall_pat = 8'hFF;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
                stall_pat = 8'($urandom) | 8'h01;  // never all stalled
            end
            mode_left--;
            case (mode)
                RX_OPEN:    out_ch.ready = 1'b1;
                RX_RANDOM:  out_ch.ready = 1'($urandom_range(0, 1));
                RX_SPARSE:  out_ch.ready = ($urandom_range(0, 3) == 0);
                RX_PATTERN: begin
                    out_ch.ready = stall_pat[0];
                    stall_pat    = {stall_pat[0], stall_pat[7:1]};
                end
                default:    out_ch.ready = 1'b1;
            endcase
        end
    end

    initial begin : tx_side
        int k;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func  = FUNC_LOAD1;
        in_ch.coeff = '0;
        in_ch.exp_x = '0;
        in_ch.exp_y = '0;
        in_ch.exp_z = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // compute on empty tables gives nothing; selector 3 is dropped
        drive_item(FUNC_COMPUTE, 32'h0, 8'd0, 8'd0, 8'd0);
        drive_item(FUNC_IGNORED, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255);
        // wrapping sums at both coefficient extremes, exponent extremes;
        // the all-zero table-one term matches two table-two terms
        drive_item(FUNC_LOAD1, 32'h7FFF_FFFF, 8'd255, 8'd255, 8'd255);
        drive_item(FUNC_LOAD1, 32'h8000_0000, 8'd0, 8'd0, 8'd0);
        drive_item(FUNC_LOAD1, 32'd5, 8'd1, 8'd2, 8'd3);
        drive_item(FUNC_LOAD2, 32'd1, 8'd255, 8'd255, 8'd255);
        drive_item(FUNC_LOAD2, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
        drive_item(FUNC_LOAD2, 32'd7, 8'd3, 8'd2, 8'd1);
        drive_item(FUNC_LOAD2, 32'd9, 8'd0, 8'd0, 8'd0);
        drive_item(FUNC_COMPUTE, 32'h0, 8'd0, 8'd0, 8'd0);
        // only table two, then only table one
        drive_item(FUNC_LOAD2, 32'h1234_5678, 8'hAA, 8'h55, 8'h0F);
        drive_item(FUNC_LOAD2, 32'hEDCB_A987, 8'h55, 8'hAA, 8'hF0);
        drive_item(FUNC_COMPUTE, 32'h0, 8'd0, 8'd0, 8'd0);
        drive_item(FUNC_LOAD1, 32'hDEAD_BEEF, 8'h80, 8'h7F, 8'h01);
        drive_item(FUNC_COMPUTE, 32'h0, 8'd0, 8'd0, 8'd0);
        // one load past a full table one is dropped
        for (k = 0; k <= MAX_TERMS; k++)
            drive_item(FUNC_LOAD1, 32'(k * 1000 + 1), 8'd1, 8'd1, 8'd1);
        drive_item(FUNC_LOAD2, 32'd42, 8'd1, 8'd1, 8'd1);
        drive_item(FUNC_COMPUTE, 32'h0, 8'd0, 8'd0, 8'd0);

        // --- random polynomial pairs ---
        while (sent_items < ITEM_TARGET) begin
            if (!hold_req && sent_items > ITEM_TARGET / 2) begin
                // full tables, one shared exponent, under a long hold-off
                hold_req = 1'b1;
                run_poly_pair(MAX_TERMS, MAX_TERMS, 1);
            end else if ($urandom_range(0, 9) == 0) begin
                run_poly_pair(MAX_TERMS, MAX_TERMS, 1);
            end else begin
                run_poly_pair(rand_count(), rand_count(), $urandom_range(1, 4));
            end
        end
        in_ch.valid = 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("tb_sparse_poly_term_adder: clean");
        else
            $display("tb_sparse_poly_term_adder: errors");
        $finish;
    end

endmodule
